// ===== rtl/core/gpst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the pin state table block.
// No dependencies; the front end, queue, back end and top level import this package.
package gpst_pkg;

	localparam int PIN_W       = 6;
	localparam int TIME_W      = 32;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] MODE_IN   = 2'd0;
	localparam logic [1:0] MODE_OUT  = 2'd1;
	localparam logic [1:0] MODE_NONE = 2'd2;

	typedef enum logic [2:0] {
		OP_SET_MODE   = 3'd0,
		OP_DRIVE      = 3'd1,
		OP_FORCE      = 3'd2,
		OP_READ_MODE  = 3'd3,
		OP_READ_LEVEL = 3'd4,
		OP_SNAPSHOT   = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_BAD_MODE   = 3'd1,
		ST_BAD_PIN    = 3'd2,
		ST_BAD_LEVEL  = 3'd3,
		ST_UNDEFINED  = 3'd4,
		ST_NOT_OUTPUT = 3'd5,
		ST_FORCED     = 3'd6
	} status_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [PIN_W-1:0]  pin;
		logic [1:0]        mode;
		logic [1:0]        value;
		logic [TIME_W-1:0] time_req;
	} req_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [PIN_W-1:0]  pin_out;
		logic [1:0]        mode_out;
		logic              level_out;
		logic              forced_out;
		logic [TIME_W-1:0] time_out;
		logic              last;
	} rsp_t;

	// Classified request as it sits in the queue
	typedef struct packed {
		op_t               op;
		status_t           pre;
		logic [PIN_W-1:0]  pin;
		logic [1:0]        mode;
		logic [1:0]        value;
		logic [TIME_W-1:0] time_req;
	} cmd_t;

	typedef struct packed {
		logic              defined;
		logic              forced;
		logic              changed;
		logic [1:0]        mode;
		logic              level;
	} entry_t;

	typedef struct packed {
		logic              scanning;
		logic [CNT_W-1:0]  cnt;
	} back_stat_t;

endpackage

// ===== rtl/core/gpst_stream_if.sv =====
`timescale 1ns / 1ps
// Valid/ready stream channel with a typed payload.
// No dependencies; the payload type is chosen where the channel is declared.
interface gpst_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/gpst_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, checks arguments that need no table lookup.
// Depends on gpst_pkg and gpst_stream_if.
module gpst_front import gpst_pkg::*; #(
	parameter int NUM_PINS = 16
) (
	gpst_stream_if.sink      req,
	input  logic             q_full,
	output logic             push,
	output cmd_t             cmd
);

	logic pin_ok;
	logic known;
	op_t  op;

	assign pin_ok = {1'b0, req.data.pin} < (PIN_W + 1)'(NUM_PINS);
	assign known  = req.data.req_type <= OP_SNAPSHOT;
	assign op     = op_t'(req.data.req_type);

	assign req.ready = !q_full;
	// drop unused request types: accepted, nothing queued
	assign push      = req.valid && !q_full && known;

	always_comb begin
		cmd          = '0;
		cmd.op       = op;
		cmd.pin      = req.data.pin;
		cmd.mode     = req.data.mode;
		cmd.value    = req.data.value;
		cmd.time_req = req.data.time_req;
		cmd.pre      = ST_OK;
		unique case (op)
			OP_SET_MODE: begin
				if (req.data.mode > MODE_OUT) cmd.pre = ST_BAD_MODE;
				else if (!pin_ok)             cmd.pre = ST_BAD_PIN;
			end
			OP_DRIVE, OP_FORCE: begin
				if (req.data.value > 2'd1) cmd.pre = ST_BAD_LEVEL;
				else if (!pin_ok)          cmd.pre = ST_BAD_PIN;
			end
			OP_READ_MODE, OP_READ_LEVEL: begin
				if (!pin_ok) cmd.pre = ST_BAD_PIN;
			end
			default: cmd.pre = ST_OK;
		endcase
	end

endmodule

// ===== rtl/core/gpst_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified requests between front and back end.
// Depends on gpst_pkg.
module gpst_queue import gpst_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full       = cnt_q == 2'd2;
	assign head_valid = cnt_q != 2'd0;
	assign head_cmd   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			priority if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)     cnt_q <= cnt_q - 2'd1;
			else                       cnt_q <= cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

endmodule

// ===== rtl/core/gpst_back.sv =====
`timescale 1ns / 1ps
// Back end: holds the pin table, executes queued requests, scans for snapshots.
// Depends on gpst_pkg and gpst_stream_if.
module gpst_back import gpst_pkg::*; #(
	parameter int NUM_PINS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  cmd_t          cmd,
	output logic          cmd_pop,
	gpst_stream_if.source rsp,
	output back_stat_t    stat
);

	localparam int IW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

	entry_t          tbl_q [NUM_PINS];
	logic [IW-1:0]   scan_i_q;
	logic [CNT_W-1:0] cnt_q;
	logic            out_v_q;
	rsp_t            out_q;

	logic                is_snap;
	logic                out_free;
	logic [IW-1:0]       addr;
	entry_t              ent;
	entry_t              ent_new;
	logic                we;
	logic                emit;
	logic                scan_adv;
	logic                scan_done;
	logic                more_hits;
	logic [NUM_PINS-1:0] hit_vec;
	logic [NUM_PINS-1:0] above;
	rsp_t                res;

	assign is_snap  = cmd_valid && (cmd.op == OP_SNAPSHOT);
	assign out_free = !out_v_q || rsp.ready;
	assign addr     = is_snap ? scan_i_q : cmd.pin[IW-1:0];
	assign ent      = tbl_q[addr];

	always_comb begin
		for (int j = 0; j < NUM_PINS; j++) begin
			hit_vec[j] = tbl_q[j].defined && tbl_q[j].changed;
			above[j]   = IW'(j) > scan_i_q;
		end
	end
	assign more_hits = |(hit_vec & above);

	always_comb begin
		we         = 1'b0;
		ent_new    = ent;
		emit       = 1'b0;
		scan_adv   = 1'b0;
		scan_done  = 1'b0;
		res        = '0;
		res.pin_out = cmd.pin;
		res.status = cmd.pre;
		res.last   = 1'b1;
		if (cmd_valid && !is_snap && out_free) begin
			emit = 1'b1;
			if (cmd.pre == ST_OK) begin
				unique case (cmd.op)
					OP_SET_MODE: begin
						we = 1'b1;
						if (ent.defined) begin
							if (ent.mode != cmd.mode) ent_new.changed = 1'b1;
							ent_new.mode  = cmd.mode;
							ent_new.level = 1'b0;
						end else begin
							ent_new = '{defined: 1'b1, forced: 1'b0, changed: 1'b1,
								mode: cmd.mode, level: 1'b0};
						end
					end
					OP_DRIVE: begin
						priority if (!ent.defined) begin
							res.status = ST_UNDEFINED;
						end else if (ent.mode != MODE_OUT) begin
							res.status = ST_NOT_OUTPUT;
						end else if (ent.level != cmd.value[0]) begin
							we              = 1'b1;
							ent_new.changed = 1'b1;
							ent_new.level   = cmd.value[0];
							ent_new.forced  = 1'b0;
						end else begin
							we = 1'b0;
						end
					end
					OP_FORCE: begin
						we = 1'b1;
						if (ent.defined) begin
							if (ent.level != cmd.value[0]) begin
								ent_new.changed = 1'b1;
								ent_new.level   = cmd.value[0];
							end
						end else begin
							ent_new = '{defined: 1'b1, forced: 1'b1, changed: 1'b1,
								mode: MODE_NONE, level: cmd.value[0]};
						end
					end
					OP_READ_MODE, OP_READ_LEVEL: begin
						if (!ent.defined) begin
							res.status = ST_UNDEFINED;
						end else begin
							res.status     = (cmd.op == OP_READ_LEVEL && ent.forced) ?
								ST_FORCED : ST_OK;
							res.mode_out   = ent.mode;
							res.level_out  = ent.level;
							res.forced_out = ent.forced;
						end
					end
					default: we = 1'b0;
				endcase
			end
		end else if (is_snap) begin
			if (hit_vec[scan_i_q]) begin
				if (out_free) begin
					emit            = 1'b1;
					we              = 1'b1;
					ent_new.changed = 1'b0;
					res.status      = ST_OK;
					res.pin_out     = PIN_W'(scan_i_q);
					res.mode_out    = ent.mode;
					res.level_out   = ent.level;
					res.forced_out  = ent.forced;
					res.time_out    = cmd.time_req;
					// final record: result budget spent or no changed pin further up
					res.last        = (cnt_q == CNT_W'(MAX_RESULTS - 1)) || !more_hits;
					scan_done       = res.last;
					scan_adv        = !res.last;
				end
			end else if (scan_i_q == IW'(NUM_PINS - 1)) begin
				scan_done = 1'b1;
			end else begin
				scan_adv = 1'b1;
			end
		end
	end

	assign cmd_pop = (cmd_valid && !is_snap && out_free) || scan_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_PINS; j++) tbl_q[j] <= '0;
			scan_i_q <= '0;
			cnt_q    <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (we) tbl_q[addr] <= ent_new;
			if (scan_done) begin
				scan_i_q <= '0;
				cnt_q    <= '0;
			end else if (scan_adv) begin
				scan_i_q <= scan_i_q + IW'(1);
				if (emit) cnt_q <= cnt_q + CNT_W'(1);
			end
			if (emit)           out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= res;
	end

	assign rsp.valid     = out_v_q;
	assign rsp.data      = out_q;
	assign stat.scanning = is_snap;
	assign stat.cnt      = cnt_q;

endmodule

// ===== rtl/core/gpio_pin_state_table_with_change_log.sv =====
`timescale 1ns / 1ps
// Top level of the pin state table with change snapshot.
// Depends on gpst_pkg, gpst_stream_if, gpst_front, gpst_queue and gpst_back.
//
// Usage:
//   req carries one request item (req_type, pin, mode, value, time_req);
//   rsp carries result items (status, pin_out, mode_out, level_out,
//   forced_out, time_out, last). Both are valid/ready channels.
//   Set mode, drive, force, read mode and read level each give one result,
//   registered through a queue entry and then the output register, and
//   one such request is taken per cycle unless rsp stalls or a snapshot runs.
//   A snapshot walks the table one pin per cycle, waiting at a changed pin
//   while rsp stalls, and holds the back end until it ends; each changed,
//   defined pin yields one record (at most 16 per snapshot), the final one
//   with last set. A snapshot that finds nothing gives no result.
//   Request types 6 and 7 are taken and dropped.
//   Reset clears the whole table at once; no clearing pass follows.
//   When rsp stalls, the output register holds its item, the two-entry
//   queue fills and req.ready falls; nothing is lost.
module gpio_pin_state_table_with_change_log import gpst_pkg::*; #(
	parameter int NUM_PINS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	gpst_stream_if.sink   req,
	gpst_stream_if.source rsp
);

	logic       push;
	cmd_t       push_cmd;
	logic       q_full;
	logic       q_valid;
	cmd_t       q_cmd;
	logic       q_pop;
	back_stat_t stat;

	gpst_front #(.NUM_PINS(NUM_PINS)) u_front (
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.cmd    (push_cmd)
	);

	gpst_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_cmd   (q_cmd)
	);

	gpst_back #(.NUM_PINS(NUM_PINS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd       (q_cmd),
		.cmd_pop   (q_pop),
		.rsp       (rsp),
		.stat      (stat)
	);

	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status != ST_OK && rsp.data.status != ST_FORCED
		|-> rsp.data.last)
		else $error("error result not marked last");

	a_scan_budget: assert property (@(posedge clk) disable iff (!arst_n)
		stat.cnt <= CNT_W'(MAX_RESULTS))
		else $error("snapshot record count beyond limit");

	a_stamp_only_snapshot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.time_out != '0 |-> rsp.data.status == ST_OK)
		else $error("time stamp on a non-snapshot result");

	a_accept_queues: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.data.req_type <= OP_SNAPSHOT |=> q_valid)
		else $error("accepted request missing from queue");

endmodule
